>>> rtl/lhcs_pkg.sv
// Package: shared types, constants and helpers for the link header check and scrub block.
package lhcs_pkg;

    localparam int MAX_WINDOW = 18;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int QDEPTH     = 4;               // power of two, pointers wrap
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_LINK_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IPV4_FAMILY = 1'd1;

    localparam logic [1:0] MODE_NULL   = 2'd0;
    localparam logic [1:0] MODE_ETHER  = 2'd1;
    localparam logic [1:0] MODE_RAW    = 2'd2;
    localparam logic [1:0] MODE_COOKED = 2'd3;

    localparam logic [1:0] VERDICT_OK       = 2'd0;
    localparam logic [1:0] VERDICT_SHORT    = 2'd1;
    localparam logic [1:0] VERDICT_NOT_IPV4 = 2'd2;

    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] TYPE_QTAG = 16'h8100;

    localparam logic [CNT_W-1:0] HDR_NULL      = CNT_W'(4);
    localparam logic [CNT_W-1:0] HDR_ETHER     = CNT_W'(14);
    localparam logic [CNT_W-1:0] HDR_ETHER_TAG = CNT_W'(18);
    localparam logic [CNT_W-1:0] HDR_COOKED    = CNT_W'(16);
    localparam logic [CNT_W-1:0] HDR_RAW       = CNT_W'(0);
    localparam logic [CNT_W-1:0] MAC_END       = CNT_W'(12);
    localparam logic [CNT_W-1:0] COOKED_ADDR_LO = CNT_W'(4);
    localparam logic [CNT_W-1:0] COOKED_ADDR_HI = CNT_W'(14);

    localparam logic [1:0]  RST_LINK_MODE = MODE_ETHER;
    localparam logic [31:0] RST_FAMILY    = 32'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] verdict;
        logic [4:0] header_len;
    } out_item_t;

    typedef struct packed {
        out_item_t        item;
        logic             hdr;     // byte came from the header window
        logic [IDX_W-1:0] idx;     // position inside the window
    } q_entry_t;

    typedef struct packed {
        logic [1:0]  link_mode;
        logic [31:0] ipv4_family_value;
    } cfg_t;

    typedef struct packed {
        logic deciding;
        logic replaying;
    } front_stat_t;

    function automatic logic [CNT_W-1:0] window_size(input logic [1:0] mode);
        logic [CNT_W-1:0] w;
        unique case (mode)
            MODE_NULL:   w = HDR_NULL;
            MODE_ETHER:  w = HDR_ETHER_TAG;
            MODE_COOKED: w = HDR_COOKED;
            MODE_RAW:    w = HDR_RAW;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/lhcs_front.sv
// Front end: captures the header window, classifies the packet and feeds the queue.
module lhcs_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lhcs_pkg::cfg_t        cfg,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  lhcs_pkg::in_item_t    byte_data,
    input  logic                  q_full,
    output logic                  q_push,
    output lhcs_pkg::q_entry_t    q_entry,
    output lhcs_pkg::front_stat_t stat
);

    typedef enum logic [3:0] {
        ST_COLLECT = 4'b0001,
        ST_DECIDE  = 4'b0010,
        ST_REPLAY  = 4'b0100,
        ST_PASS    = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [lhcs_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [lhcs_pkg::IDX_W-1:0]     rp_idx_reg, rp_idx_next;
    logic [1:0]                     verdict_reg, verdict_next;
    logic [lhcs_pkg::CNT_W-1:0]     hl_reg, hl_next;
    logic                           last_reg, last_next;
    logic [7:0]                     store_reg [lhcs_pkg::MAX_WINDOW];

    logic                           accept;
    logic [lhcs_pkg::CNT_W-1:0]     count_inc;
    logic                           rp_final;
    logic [1:0]                     dec_v;
    logic [lhcs_pkg::CNT_W-1:0]     dec_hl;
    logic [31:0]                    family;
    logic [15:0]                    type_outer;
    logic [15:0]                    type_inner;
    logic [15:0]                    type_cooked;

    assign byte_stall = (state_reg == ST_DECIDE) || (state_reg == ST_REPLAY) ||
                        ((state_reg == ST_PASS) && q_full);
    assign accept     = byte_valid && !byte_stall;
    assign count_inc  = (count_reg < lhcs_pkg::CNT_W'(lhcs_pkg::MAX_WINDOW)) ?
                        count_reg + lhcs_pkg::CNT_W'(1) : count_reg;
    assign rp_final   = (lhcs_pkg::CNT_W'(rp_idx_reg) + lhcs_pkg::CNT_W'(1)) == count_reg;

    assign stat.deciding  = (state_reg == ST_DECIDE);
    assign stat.replaying = (state_reg == ST_REPLAY);

    assign family      = {store_reg[3], store_reg[2], store_reg[1], store_reg[0]};
    assign type_outer  = {store_reg[12], store_reg[13]};
    assign type_inner  = {store_reg[16], store_reg[17]};
    assign type_cooked = {store_reg[14], store_reg[15]};

    // classification over the held window
    always_comb
    begin
        dec_v  = lhcs_pkg::VERDICT_OK;
        dec_hl = lhcs_pkg::HDR_RAW;
        unique case (cfg.link_mode)
            lhcs_pkg::MODE_NULL:
            begin
                if (count_reg < lhcs_pkg::HDR_NULL)
                    dec_v = lhcs_pkg::VERDICT_SHORT;
                else if (family != cfg.ipv4_family_value)
                    dec_v = lhcs_pkg::VERDICT_NOT_IPV4;
                else
                    dec_hl = lhcs_pkg::HDR_NULL;
            end
            lhcs_pkg::MODE_COOKED:
            begin
                if (count_reg < lhcs_pkg::HDR_COOKED)
                    dec_v = lhcs_pkg::VERDICT_SHORT;
                else if (type_cooked != lhcs_pkg::TYPE_IPV4)
                    dec_v = lhcs_pkg::VERDICT_NOT_IPV4;
                else
                    dec_hl = lhcs_pkg::HDR_COOKED;
            end
            lhcs_pkg::MODE_ETHER:
            begin
                if (count_reg < lhcs_pkg::HDR_ETHER)
                    dec_v = lhcs_pkg::VERDICT_SHORT;
                else if (type_outer == lhcs_pkg::TYPE_QTAG)
                begin
                    if (count_reg < lhcs_pkg::HDR_ETHER_TAG)
                        dec_v = lhcs_pkg::VERDICT_SHORT;
                    else if (type_inner != lhcs_pkg::TYPE_IPV4)
                        dec_v = lhcs_pkg::VERDICT_NOT_IPV4;
                    else
                        dec_hl = lhcs_pkg::HDR_ETHER_TAG;
                end
                else if (type_outer != lhcs_pkg::TYPE_IPV4)
                    dec_v = lhcs_pkg::VERDICT_NOT_IPV4;
                else
                    dec_hl = lhcs_pkg::HDR_ETHER;
            end
            lhcs_pkg::MODE_RAW:
            begin
                dec_hl = lhcs_pkg::HDR_RAW;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rp_idx_next  = rp_idx_reg;
        verdict_next = verdict_reg;
        hl_next      = hl_reg;
        last_next    = last_reg;
        q_push       = 1'b0;
        q_entry.item.out_byte   = byte_data.data_byte;
        q_entry.item.out_last   = byte_data.last_byte;
        q_entry.item.verdict    = verdict_reg;
        q_entry.item.header_len = hl_reg;
        q_entry.hdr             = 1'b0;
        q_entry.idx             = rp_idx_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (accept)
                begin
                    count_next = count_inc;
                    last_next  = byte_data.last_byte;
                    if ((count_inc >= lhcs_pkg::window_size(cfg.link_mode)) ||
                        byte_data.last_byte)
                        state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                verdict_next = dec_v;
                hl_next      = dec_hl;
                rp_idx_next  = '0;
                state_next   = ST_REPLAY;
            end
            ST_REPLAY:
            begin
                q_entry.item.out_byte = store_reg[rp_idx_reg];
                q_entry.item.out_last = rp_final && last_reg;
                q_entry.hdr           = 1'b1;
                q_push                = !q_full;
                if (!q_full)
                begin
                    if (rp_final)
                    begin
                        count_next = '0;
                        state_next = last_reg ? ST_COLLECT : ST_PASS;
                    end
                    else
                        rp_idx_next = rp_idx_reg + lhcs_pkg::IDX_W'(1);
                end
            end
            ST_PASS:
            begin
                q_push = accept;
                if (accept && byte_data.last_byte)
                    state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            count_reg   <= '0;
            rp_idx_reg  <= '0;
            verdict_reg <= lhcs_pkg::VERDICT_OK;
            hl_reg      <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rp_idx_reg  <= rp_idx_next;
            verdict_reg <= verdict_next;
            hl_reg      <= hl_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_COLLECT) && accept &&
            (count_reg < lhcs_pkg::CNT_W'(lhcs_pkg::MAX_WINDOW)))
            store_reg[count_reg[lhcs_pkg::IDX_W-1:0]] <= byte_data.data_byte;
    end

endmodule

>>> rtl/lhcs_queue.sv
// Queue: short FIFO of classified byte transactions between front and back.
module lhcs_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lhcs_pkg::q_entry_t push_data,
    input  logic               pop,
    output lhcs_pkg::q_entry_t pop_data,
    output logic               full,
    output logic               empty
);

    lhcs_pkg::q_entry_t            mem [lhcs_pkg::QDEPTH];
    logic [lhcs_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [lhcs_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [lhcs_pkg::QPTR_W:0]     fill_reg, fill_next;
    logic                          do_push;
    logic                          do_pop;

    assign full     = (fill_reg == (lhcs_pkg::QPTR_W + 1)'(lhcs_pkg::QDEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + lhcs_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + lhcs_pkg::QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + (lhcs_pkg::QPTR_W + 1)'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - (lhcs_pkg::QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

>>> rtl/lhcs_back.sv
// Back end: scrubs address bytes of accepted headers and drives the result register.
module lhcs_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lhcs_pkg::q_entry_t    q_entry,
    input  logic                  q_empty,
    output logic                  q_pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output lhcs_pkg::out_item_t   result_data
);

    logic                         valid_reg, valid_next;
    lhcs_pkg::out_item_t          data_reg;
    lhcs_pkg::out_item_t          scrubbed;
    logic [lhcs_pkg::CNT_W-1:0]   pos;
    logic                         is_ether;
    logic                         is_cooked;
    logic                         zero_it;

    assign pos       = lhcs_pkg::CNT_W'(q_entry.idx);
    assign is_ether  = (q_entry.item.header_len == lhcs_pkg::HDR_ETHER) ||
                       (q_entry.item.header_len == lhcs_pkg::HDR_ETHER_TAG);
    assign is_cooked = (q_entry.item.header_len == lhcs_pkg::HDR_COOKED);
    assign zero_it   = q_entry.hdr && (q_entry.item.verdict == lhcs_pkg::VERDICT_OK) &&
                       ((is_ether && (pos < lhcs_pkg::MAC_END)) ||
                        (is_cooked && (pos >= lhcs_pkg::COOKED_ADDR_LO) &&
                         (pos < lhcs_pkg::COOKED_ADDR_HI)));

    always_comb
    begin
        scrubbed = q_entry.item;
        if (zero_it)
            scrubbed.out_byte = 8'h00;
    end

    assign q_pop      = !q_empty && (!valid_reg || !result_stall);
    assign valid_next = q_pop || (valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            data_reg <= scrubbed;
    end

    assign result_valid = valid_reg;
    assign result_data  = data_reg;

endmodule

>>> rtl/link_header_check_and_scrub_core.sv
// Top level: link header check and scrub core with configuration registers.
//
//   channel   direction  handshake                  payload
//   byte      in         byte_valid / byte_stall    byte_data   (lhcs_pkg::in_item_t)
//   result    out        result_valid / result_stall result_data (lhcs_pkg::out_item_t)
//   cfg       in         cfg_write_en               cfg_index, cfg_data
//
// Bytes after the decision pass at one transaction per cycle while the queue
// is not full. The header window takes its n bytes at one per cycle, then the
// decision state, then the replay of those n bytes out of the 18-byte window
// store, one store read a cycle, each waiting while the queue is full; input is
// held off during decision and replay. Reset: link_mode ethernet, family value
// 2, queue and result register empty. The 4-entry queue lets the back end stall
// on result_stall without stopping passthrough capture until it fills.
module link_header_check_and_scrub_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              byte_valid,
    output logic                              byte_stall,
    input  lhcs_pkg::in_item_t                byte_data,
    output logic                              result_valid,
    input  logic                              result_stall,
    output lhcs_pkg::out_item_t               result_data,
    input  logic                              cfg_write_en,
    input  logic [lhcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lhcs_pkg::CFG_W-1:0]        cfg_data
);

    logic [1:0]             link_mode_reg;
    logic [31:0]            family_reg;
    lhcs_pkg::cfg_t         cfg;
    lhcs_pkg::front_stat_t  stat;
    lhcs_pkg::q_entry_t     push_entry;
    lhcs_pkg::q_entry_t     pop_entry;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_mode_reg <= lhcs_pkg::RST_LINK_MODE;
            family_reg    <= lhcs_pkg::RST_FAMILY;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                lhcs_pkg::CFG_LINK_MODE:   link_mode_reg <= cfg_data[1:0];
                lhcs_pkg::CFG_IPV4_FAMILY: family_reg    <= cfg_data;
            endcase
        end
    end

    assign cfg.link_mode         = link_mode_reg;
    assign cfg.ipv4_family_value = family_reg;

    lhcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (push_entry),
        .stat       (stat)
    );

    lhcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_entry),
        .pop       (q_pop),
        .pop_data  (pop_entry),
        .full      (q_full),
        .empty     (q_empty)
    );

    lhcs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_entry      (pop_entry),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    a_hold_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.deciding || stat.replaying) |-> byte_stall)
        else $error("input taken during decision or replay");

    a_decide_then_replay: assert property (@(posedge clk) disable iff (!rst_n)
        stat.deciding |=> stat.replaying)
        else $error("decision not followed by replay");

    a_reject_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_data.verdict != lhcs_pkg::VERDICT_OK))
            |-> (result_data.header_len == '0))
        else $error("rejected packet carries a header length");
`endif

endmodule
